// ===== hw/rtl/skt_pkg.sv =====
package skt_pkg;

   localparam int CAPACITY    = 16;
   localparam int KEY_BITS    = 10;
   localparam int SLOT_BITS   = $clog2(CAPACITY);
   localparam int CNT_BITS    = $clog2(CAPACITY + 1);
   localparam int OP_BITS     = 2;
   localparam int STATUS_BITS = 2;

   typedef enum logic [OP_BITS-1:0] {
      OP_LOOKUP = 2'd0,
      OP_INSERT = 2'd1,
      OP_REMOVE = 2'd2
   } op_type;

   typedef enum logic [STATUS_BITS-1:0] {
      STATUS_OK   = 2'd0,
      STATUS_MISS = 2'd1,
      STATUS_FULL = 2'd2,
      STATUS_DUP  = 2'd3
   } status_type;

   typedef struct packed {
      logic [OP_BITS-1:0]   operation;
      logic [KEY_BITS-1:0]  key;
      logic [SLOT_BITS-1:0] slot;
   } req_type;

   typedef struct packed {
      logic                   found;
      logic [CNT_BITS-1:0]    position;
      logic [STATUS_BITS-1:0] status;
      logic [CNT_BITS-1:0]    count;
   } rsp_type;

   // controller -> datapath
   typedef struct packed {
      logic capture;   // latch request beat, register key compares
      logic commit;    // apply update, load result register
   } cmd_type;

endpackage

// ===== hw/rtl/sorted_key_table_top.sv =====
// A request beat accepted at the capturing edge has its key compares registered, and the
// controller's commit step then loads its result beat; a stalled result register holds
//   the commit step until it drains, and no new request is taken before that commit.
// A new request is taken while the previous result still waits on rsp_stall.
// Reset (synchronous, active high) empties the table and drops both handshakes;
//   key storage itself is not cleared.
module sorted_key_table_top (
   input  logic             clock,
   input  logic             reset,
   // request channel
   input  logic             req_valid,
   output logic             req_stall,
   input  skt_pkg::req_type req_payload,
   // result channel
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output skt_pkg::rsp_type rsp_payload
);

   // capture/commit strobes from the sequencer
   skt_pkg::cmd_type cmd;

   // Sequencer: idle -> commit. Capture happens on the accepting edge,
   // commit waits for room in the result register.
   skt_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .cmd       (cmd)
   );

   // Datapath: sorted key registers, per-entry compares, lower-bound
   // encode, insert/remove shift and the result register.
   skt_datapath u_datapath (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .req_payload (req_payload),
      .rsp_payload (rsp_payload)
   );

endmodule

// ===== hw/rtl/skt_ctrl.sv =====
module skt_ctrl (
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_stall,
   output logic            rsp_valid,
   input  logic            rsp_stall,
   output skt_pkg::cmd_type cmd
);

   typedef enum logic {
      ST_IDLE,
      ST_COMMIT
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      out_free;

   assign out_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      cmd.capture  = 1'b0;
      cmd.commit   = 1'b0;
      state_in     = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = ST_COMMIT;
            end
         end
         ST_COMMIT: begin
            // wait here while the previous result is still held off
            if (out_free) begin
               cmd.commit = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase

      if (cmd.commit) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

endmodule

// ===== hw/rtl/skt_datapath.sv =====
module skt_datapath (
   input  logic             clock,
   input  logic             reset,
   input  skt_pkg::cmd_type cmd,
   input  skt_pkg::req_type req_payload,
   output skt_pkg::rsp_type rsp_payload
);

   logic [skt_pkg::KEY_BITS-1:0]  keys_ff [skt_pkg::CAPACITY];
   logic [skt_pkg::KEY_BITS-1:0]  keys_in [skt_pkg::CAPACITY];
   logic [skt_pkg::CNT_BITS-1:0]  count_ff, count_in;

   logic [skt_pkg::OP_BITS-1:0]   op_ff;
   logic [skt_pkg::KEY_BITS-1:0]  key_ff;
   logic [skt_pkg::SLOT_BITS-1:0] slot_ff;
   logic [skt_pkg::CAPACITY-1:0]  lt_ff, lt_in;
   logic [skt_pkg::CAPACITY-1:0]  eq_ff, eq_in;

   skt_pkg::rsp_type              rsp_ff, rsp_in;

   logic [skt_pkg::CNT_BITS-1:0]  lower;
   logic [skt_pkg::CNT_BITS-1:0]  slot_ext;
   logic                          hit;
   logic                          full;
   logic                          do_insert;
   logic                          do_remove;

   // per-entry compares against the incoming key, valid entries only
   always_comb begin
      for (int i = 0; i < skt_pkg::CAPACITY; i++) begin
         lt_in[i] = (skt_pkg::CNT_BITS'(i) < count_ff) && (keys_ff[i] < req_payload.key);
         eq_in[i] = (skt_pkg::CNT_BITS'(i) < count_ff) && (keys_ff[i] == req_payload.key);
      end
   end

   // lt is a thermometer (table is sorted): lower bound is its first zero
   always_comb begin
      lower = skt_pkg::CNT_BITS'(skt_pkg::CAPACITY);
      for (int i = skt_pkg::CAPACITY - 1; i >= 0; i--) begin
         if (!lt_ff[i]) begin
            lower = skt_pkg::CNT_BITS'(i);
         end
      end
   end

   assign hit      = |eq_ff;
   assign full     = (count_ff == skt_pkg::CNT_BITS'(skt_pkg::CAPACITY));
   assign slot_ext = skt_pkg::CNT_BITS'(slot_ff);

   always_comb begin
      do_insert       = 1'b0;
      do_remove       = 1'b0;
      rsp_in.found    = 1'b0;
      rsp_in.position = '0;
      rsp_in.status   = skt_pkg::STATUS_MISS;
      unique case (op_ff)
         skt_pkg::OP_LOOKUP: begin
            rsp_in.found    = hit;
            rsp_in.position = lower;
            rsp_in.status   = hit ? skt_pkg::STATUS_OK : skt_pkg::STATUS_MISS;
         end
         skt_pkg::OP_INSERT: begin
            rsp_in.found    = hit;
            rsp_in.position = lower;
            priority if (hit) begin
               rsp_in.status = skt_pkg::STATUS_DUP;
            end else if (full) begin
               rsp_in.status = skt_pkg::STATUS_FULL;
            end else begin
               rsp_in.status = skt_pkg::STATUS_OK;
               do_insert     = 1'b1;
            end
         end
         skt_pkg::OP_REMOVE: begin
            rsp_in.position = slot_ext;
            if (slot_ext < count_ff) begin
               rsp_in.found  = 1'b1;
               rsp_in.status = skt_pkg::STATUS_OK;
               do_remove     = 1'b1;
            end
         end
         default: ;
      endcase

      priority if (do_insert) begin
         count_in = count_ff + 1'b1;
      end else if (do_remove) begin
         count_in = count_ff - 1'b1;
      end else begin
         count_in = count_ff;
      end
      rsp_in.count = count_in;
   end

   // shift line: each entry keeps its value, takes a neighbor's, or takes the new key
   always_comb begin
      for (int i = 0; i < skt_pkg::CAPACITY; i++) begin
         keys_in[i] = keys_ff[i];
         if (do_insert) begin
            if (skt_pkg::CNT_BITS'(i) == lower) begin
               keys_in[i] = key_ff;
            end else if (i > 0 && skt_pkg::CNT_BITS'(i) > lower) begin
               keys_in[i] = keys_ff[(i > 0) ? i - 1 : 0];
            end
         end else if (do_remove) begin
            if (i < skt_pkg::CAPACITY - 1 && skt_pkg::CNT_BITS'(i) >= slot_ext) begin
               keys_in[i] = keys_ff[(i < skt_pkg::CAPACITY - 1) ? i + 1 : i];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else if (cmd.commit) begin
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         op_ff   <= req_payload.operation;
         key_ff  <= req_payload.key;
         slot_ff <= req_payload.slot;
         lt_ff   <= lt_in;
         eq_ff   <= eq_in;
      end
      if (cmd.commit) begin
         keys_ff <= keys_in;
         rsp_ff  <= rsp_in;
      end
   end

   assign rsp_payload = rsp_ff;

endmodule

// ===== tb/sorted_key_table_top_tb.sv =====
`timescale 1ns / 100ps

module sorted_key_table_top_tb;
   import skt_pkg::*;

   localparam int CYCLE_LIMIT  = 400000;   // watchdog limit, well above the slowest legal run
   localparam int MAX_IDLE     = 17;       // per-beat idle/stall draw upper bound
   localparam int LONG_HOLD    = 150;      // receiver hold-off, in cycles
   localparam int RANDOM_ITEMS = 1800;
   localparam int FLUSH_CYCLES = 20;       // idle wait before the final check
   localparam logic [OP_BITS-1:0] OP_UNUSED = 2'd3;

   logic    clock;
   logic    reset;
   logic    req_valid;
   logic    req_stall;
   req_type req_payload;
   logic    rsp_valid;
   logic    rsp_stall;
   rsp_type rsp_payload;

   int max_gap = MAX_IDLE;   // shared idle bound; 0 gives back-to-back stretches
   bit long_hold;            // asks the receiver for one long stall
   int results_seen;
   int cycles;

   // Scoreboard: shadow copy of the sorted table plus the queue of results
   // still owed by the block, in request order.
   class key_table_scoreboard;
      logic [KEY_BITS-1:0] table_keys [CAPACITY];
      int                  entry_count;
      rsp_type             pending_results [$];
      int                  error_count;

      function int entries();
         return entry_count;
      endfunction

      function logic [KEY_BITS-1:0] key_at(int idx);
         return table_keys[idx];
      endfunction

      function int outstanding();
         return pending_results.size();
      endfunction

      // Lower-bound search for lookup and insert, then apply any update to the shadow table.
      function rsp_type table_response(req_type r);
         rsp_type e;
         int      lo;
         int      hi;
         int      mid;
         int      i;
         bit      hit;
         e        = '0;
         e.status = STATUS_MISS;
         case (r.operation)
            OP_LOOKUP, OP_INSERT: begin
               lo = 0;
               hi = entry_count;
               while (lo < hi) begin
                  mid = lo + ((hi - lo) >> 1);
                  if (table_keys[mid] < r.key) lo = mid + 1;
                  else hi = mid;
               end
               hit        = (lo < entry_count) && (table_keys[lo] == r.key);
               e.found    = hit;
               e.position = CNT_BITS'(lo);
               if (r.operation == OP_LOOKUP) begin
                  e.status = hit ? STATUS_OK : STATUS_MISS;
               end else if (hit) begin
                  e.status = STATUS_DUP;
               end else if (entry_count >= CAPACITY) begin
                  e.status = STATUS_FULL;
               end else begin
                  for (i = entry_count; i > lo; i--) table_keys[i] = table_keys[i-1];
                  table_keys[lo] = r.key;
                  entry_count++;
                  e.status = STATUS_OK;
               end
            end
            OP_REMOVE: begin
               e.position = CNT_BITS'(r.slot);
               if (r.slot < entry_count) begin
                  for (i = r.slot; i + 1 < entry_count; i++) table_keys[i] = table_keys[i+1];
                  entry_count--;
                  e.found  = 1'b1;
                  e.status = STATUS_OK;
               end
            end
            default: ;
         endcase
         e.count = CNT_BITS'(entry_count);
         return e;
      endfunction

      function void note_request(req_type r);
         pending_results.push_back(table_response(r));
      endfunction

      function void compare_field(string name, int want, int got);
         if (want != got) begin
            $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, want, got);
            error_count++;
         end
      endfunction

      function void check_result(rsp_type got);
         rsp_type want;
         if (pending_results.size() == 0) begin
            $display("%0t: unexpected result beat: expected none, actual %h", $time, got);
            error_count++;
            return;
         end
         want = pending_results.pop_front();
         compare_field("found", want.found, got.found);
         compare_field("position", want.position, got.position);
         compare_field("status", want.status, got.status);
         compare_field("count", want.count, got.count);
      endfunction
   endclass

   key_table_scoreboard sb;

   sorted_key_table_top uut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

   // 10 ns clock
   initial clock = 1'b0;
   always #5 clock = ~clock;

   // Both monitors sample at the rising edge; drivers only move on the
   // falling edge, so there is no race with the block's registers.
   always @(posedge clock) begin
      if (!reset && req_valid && !req_stall) sb.note_request(req_payload);
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         sb.check_result(rsp_payload);
         results_seen++;
      end
   end

   // Watchdog
   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   // Result side: per beat, stall a random number of cycles, then drop
   // stall until one beat goes through. A long hold-off is taken on
   // request, counted here, so the block backs up into req_stall.
   initial begin
      int n;
      int seen;
      rsp_stall = 1'b0;
      wait (reset === 1'b0);
      @(negedge clock);
      forever begin
         if (long_hold) begin
            n         = LONG_HOLD;
            long_hold = 1'b0;
         end else begin
            n = $urandom_range(0, max_gap);
         end
         if (n > 0) begin
            rsp_stall <= 1'b1;
            repeat (n) @(negedge clock);
         end
         rsp_stall <= 1'b0;
         seen = results_seen;
         while (results_seen == seen) @(negedge clock);
      end
   end

   function automatic req_type make_req(logic [OP_BITS-1:0] op, int key, int slot);
      req_type r;
      r.operation = op;
      r.key       = KEY_BITS'(key);
      r.slot      = SLOT_BITS'(slot);
      return r;
   endfunction

   // Random request biased toward the live table contents: present keys,
   // their neighbors and the key extremes, so hits, dups, full and empty
   // tables all come up often. "filling" tilts the mix toward inserts.
   function automatic req_type random_request(bit filling);
      req_type r;
      int      c;
      int      pick;
      c           = sb.entries();
      r.key       = KEY_BITS'($urandom_range(0, 1023));
      r.slot      = SLOT_BITS'($urandom_range(0, 15));
      pick        = $urandom_range(0, 99);
      if (pick < 4) r.operation = OP_UNUSED;
      else if (pick < 24) r.operation = OP_LOOKUP;
      else if (pick < (filling ? 84 : 39)) r.operation = OP_INSERT;
      else r.operation = OP_REMOVE;
      pick = $urandom_range(0, 99);
      if (c > 0 && pick < 35) begin
         r.key = sb.key_at($urandom_range(0, c - 1));
      end else if (c > 0 && pick < 50) begin
         // neighbor of a present key, wraps at the key width
         r.key = sb.key_at($urandom_range(0, c - 1));
         r.key = $urandom_range(0, 1) ? r.key + 1'b1 : r.key - 1'b1;
      end else if (pick < 60) begin
         r.key = pick[0] ? '1 : '0;
      end
      if (r.operation == OP_REMOVE && c > 0 && $urandom_range(0, 4) != 0)
         r.slot = SLOT_BITS'($urandom_range(0, c - 1));
      return r;
   endfunction

   // One request beat: idle for a drawn gap, then hold valid and payload
   // until the beat is taken. valid stays high across back-to-back beats.
   task automatic send_request(input req_type r, input int gap_max);
      int gap;
      gap = $urandom_range(0, gap_max);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid   <= 1'b1;
      req_payload <= r;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      while (sb.outstanding() != 0) @(negedge clock);
   endtask

   initial begin
      int  i;
      bit  filling;
      sb          = new();
      reset       = 1'b1;
      req_valid   = 1'b0;
      req_payload = '0;
      repeat (3) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // ---- directed: empty table, unused code, extremes, dup, misses ----
      send_request(make_req(OP_LOOKUP, 0, 0), max_gap);       // miss on empty
      send_request(make_req(OP_REMOVE, 1023, 0), max_gap);    // bad slot on empty
      send_request(make_req(OP_UNUSED, 1023, 15), max_gap);   // unused op code
      send_request(make_req(OP_INSERT, 1023, 15), max_gap);
      send_request(make_req(OP_INSERT, 0, 0), max_gap);
      send_request(make_req(OP_INSERT, 512, 7), max_gap);
      send_request(make_req(OP_INSERT, 512, 0), max_gap);     // duplicate
      send_request(make_req(OP_LOOKUP, 512, 0), max_gap);     // hit
      send_request(make_req(OP_LOOKUP, 511, 0), max_gap);     // miss, mid slot
      send_request(make_req(OP_REMOVE, 0, 15), max_gap);      // slot past count
      send_request(make_req(OP_REMOVE, 1023, 1), max_gap);    // key ignored
      // fill to capacity with descending keys, each insert shifts the tail
      for (i = 0; i < CAPACITY - 2; i++)
         send_request(make_req(OP_INSERT, 1000 - 70 * i, i), max_gap);
      send_request(make_req(OP_INSERT, 5, 0), max_gap);       // table full
      send_request(make_req(OP_LOOKUP, 1023, 0), max_gap);    // hit at top slot
      send_request(make_req(OP_REMOVE, 0, CAPACITY - 1), max_gap);
      send_request(make_req(OP_REMOVE, 0, 0), max_gap);

      // sender pause: let every owed result come back
      wait_drained();

      // ---- back-pressure: long receiver hold while requests keep coming ----
      long_hold = 1'b1;
      for (i = 0; i < 20; i++) send_request(random_request(1'b1), 0);

      // ---- random: alternate fill/drain bias, some stretches with no idling ----
      filling = 1'b1;
      for (i = 0; i < RANDOM_ITEMS; i++) begin
         if (i % 48 == 0) filling = ~filling;
         if (i % 150 == 0) max_gap = ((i / 150) % 4 == 3) ? 0 : MAX_IDLE;
         if (i == RANDOM_ITEMS / 2) wait_drained();
         send_request(random_request(filling), max_gap);
      end
      max_gap = MAX_IDLE;

      wait_drained();
      repeat (FLUSH_CYCLES) @(negedge clock);
      if (sb.error_count == 0 && sb.outstanding() == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule

// ===== files.f =====
hw/rtl/skt_pkg.sv
hw/rtl/skt_ctrl.sv
hw/rtl/skt_datapath.sv
hw/rtl/sorted_key_table_top.sv
tb/sorted_key_table_top_tb.sv
